@@ rtl/uww_pkg.sv @@
package uww_pkg;

	// Text length limit; bytes beyond it are dropped until the last byte
	localparam int unsigned MAX_TEXT_BYTES = 65536;

	localparam int unsigned POS_W   = 17;
	localparam int unsigned OFS_W   = 16;
	localparam int unsigned GW_W    = 16;
	localparam int unsigned LW_W    = 18;
	localparam int unsigned MAXW_W  = 16;

	// Result queue
	localparam int unsigned RQ_DEPTH = 4;
	localparam int unsigned RQ_PTR_W = 2;
	localparam int unsigned RQ_CNT_W = 3;

	// Register map (word index)
	localparam logic REG_MAX_WIDTH = 1'b0;
	localparam logic [MAXW_W-1:0] MAX_WIDTH_RESET = 16'hFFFF;

	// UTF-8 lead byte classes
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;
	localparam logic [7:0] ASCII_SPACE = 8'h20;

	typedef struct packed {
		logic [7:0]      text_byte;
		logic [GW_W-1:0] glyph_width;
		logic            last_byte;
	} text_item_t;

	typedef struct packed {
		logic [OFS_W-1:0] line_offset;
		logic [POS_W-1:0] line_bytes;
		logic             final_line;
	} line_item_t;

	// Continuation bytes that follow a lead byte (glyph length minus one)
	function automatic logic [1:0] glyph_tail(input logic [7:0] lead);
		logic [1:0] n;
		n = 2'd0;
		if (lead[7] == 1'b0)
			n = 2'd0;
		else if ((lead & LEAD2_MASK) == LEAD2_CODE)
			n = 2'd1;
		else if ((lead & LEAD3_MASK) == LEAD3_CODE)
			n = 2'd2;
		else if ((lead & LEAD4_MASK) == LEAD4_CODE)
			n = 2'd3;
		return n;
	endfunction

endpackage

@@ rtl/utf8_greedy_word_wrap.sv @@
// Greedy word wrap over a UTF-8 byte stream. Each text item carries one raw
// byte, the width of the glyph that byte begins (unsigned, 4 fraction bits;
// ignored on continuation bytes) and a last-byte flag. A lead byte claims
// 1 to 4 bytes for its glyph whatever they hold; malformed leads count as
// one-byte glyphs. Before a glyph that would take the open line past
// max_width the line is closed (never when empty): at the last single
// space, which is dropped, or else just before the glyph. Each closed line
// comes out as one line item (start offset, byte count, final flag); a byte
// may give none, one or two (a break line, then the final line). After the
// final line all text state clears and the next byte starts offset zero.
// Rate: one text item per clock. The whole update is one combinational pass
// from the state registers into the next state and a 4-entry result queue;
// text_stall rises while that queue has fewer than two free slots, so
// throughput is set by how fast line items are taken. Line items are
// written into the queue as their byte is accepted. max_width sits at byte
// address 0 of the APB port and must only be written while the block is idle.
module utf8_greedy_word_wrap (
	input  logic                 clk,
	input  logic                 arst_n,
	// text items
	input  logic                 text_valid,
	output logic                 text_stall,
	input  uww_pkg::text_item_t  text_item,
	// line items
	output logic                 line_valid,
	input  logic                 line_stall,
	output uww_pkg::line_item_t  line_item,
	// configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam logic [uww_pkg::POS_W-1:0] POS_LIMIT =
		uww_pkg::POS_W'(uww_pkg::MAX_TEXT_BYTES);
	localparam logic [uww_pkg::LW_W-1:0] LW_SAT = '1;

	// ---------------------------------------------------------------
	// Configuration
	// ---------------------------------------------------------------
	logic [uww_pkg::MAXW_W-1:0] max_width_q;
	logic                       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready &
	                (paddr[2] == uww_pkg::REG_MAX_WIDTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_width_q <= uww_pkg::MAX_WIDTH_RESET;
		else if (cfg_wr)
			max_width_q <= pwdata[uww_pkg::MAXW_W-1:0];
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == uww_pkg::REG_MAX_WIDTH)
			prdata = {{(32-uww_pkg::MAXW_W){1'b0}}, max_width_q};
	end

	// ---------------------------------------------------------------
	// Text state
	// ---------------------------------------------------------------
	logic [uww_pkg::POS_W-1:0] pos_q;          // offset of next byte
	logic [1:0]                left_q;         // continuation bytes owed
	logic [uww_pkg::OFS_W-1:0] start_q;        // open line start
	logic [uww_pkg::LW_W-1:0]  lw_q;           // open line width (saturating)
	logic                      sp_seen_q;
	logic [uww_pkg::OFS_W-1:0] sp_ofs_q;
	logic [uww_pkg::LW_W-1:0]  sp_lw_q;        // line width just after space

	logic [uww_pkg::POS_W-1:0] pos_d;
	logic [1:0]                left_d;
	logic [uww_pkg::OFS_W-1:0] start_d;
	logic [uww_pkg::LW_W-1:0]  lw_d;
	logic                      sp_seen_d;
	logic [uww_pkg::OFS_W-1:0] sp_ofs_d;
	logic [uww_pkg::LW_W-1:0]  sp_lw_d;

	logic                      take;
	logic                      active;
	logic                      lead;
	logic [1:0]                tail;
	logic                      over;
	logic                      brk;
	logic [uww_pkg::LW_W:0]    trial;
	logic [uww_pkg::LW_W-1:0]  lw_base;
	logic [uww_pkg::LW_W:0]    sum;
	uww_pkg::line_item_t       brk_line;
	uww_pkg::line_item_t       fin_line;

	assign take = text_valid & ~text_stall;

	always_comb begin
		pos_d     = pos_q;
		left_d    = left_q;
		start_d   = start_q;
		lw_d      = lw_q;
		sp_seen_d = sp_seen_q;
		sp_ofs_d  = sp_ofs_q;
		sp_lw_d   = sp_lw_q;

		active = pos_q < POS_LIMIT;
		lead   = (left_q == 2'd0);
		tail   = uww_pkg::glyph_tail(text_item.text_byte);
		trial  = {1'b0, lw_q} + (uww_pkg::LW_W+1)'(text_item.glyph_width);
		over   = (pos_q > {1'b0, start_q}) &&
		         (trial > (uww_pkg::LW_W+1)'(max_width_q));
		brk    = active & lead & over;

		// Line closed by the break, at the space if there is one
		brk_line.line_offset = start_q;
		brk_line.final_line  = 1'b0;
		if (sp_seen_q)
			brk_line.line_bytes = {1'b0, sp_ofs_q} - {1'b0, start_q};
		else
			brk_line.line_bytes = pos_q - {1'b0, start_q};

		lw_base = lw_q;
		if (brk) begin
			if (sp_seen_q) begin
				start_d   = sp_ofs_q + 1'b1;
				lw_base   = (lw_q >= sp_lw_q) ? (lw_q - sp_lw_q) : '0;
				sp_seen_d = 1'b0;
			end else begin
				start_d = pos_q[uww_pkg::OFS_W-1:0];
				lw_base = '0;
			end
		end
		sum = {1'b0, lw_base} + (uww_pkg::LW_W+1)'(text_item.glyph_width);

		if (active) begin
			if (!lead) begin
				left_d = left_q - 1'b1;
			end else begin
				lw_d   = sum[uww_pkg::LW_W] ? LW_SAT : sum[uww_pkg::LW_W-1:0];
				left_d = tail;
				if (tail == 2'd0 && text_item.text_byte == uww_pkg::ASCII_SPACE) begin
					sp_seen_d = 1'b1;
					sp_ofs_d  = pos_q[uww_pkg::OFS_W-1:0];
					sp_lw_d   = sum[uww_pkg::LW_W] ? LW_SAT : sum[uww_pkg::LW_W-1:0];
				end
			end
			pos_d = pos_q + 1'b1;
		end

		// Final line, seen after this byte has been folded in
		fin_line.line_offset = start_d;
		fin_line.line_bytes  = pos_d - {1'b0, start_d};
		fin_line.final_line  = 1'b1;

		if (text_item.last_byte) begin
			pos_d     = '0;
			left_d    = 2'd0;
			start_d   = '0;
			lw_d      = '0;
			sp_seen_d = 1'b0;
			sp_ofs_d  = '0;
			sp_lw_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			left_q    <= 2'd0;
			start_q   <= '0;
			lw_q      <= '0;
			sp_seen_q <= 1'b0;
			sp_ofs_q  <= '0;
			sp_lw_q   <= '0;
		end else if (take) begin
			pos_q     <= pos_d;
			left_q    <= left_d;
			start_q   <= start_d;
			lw_q      <= lw_d;
			sp_seen_q <= sp_seen_d;
			sp_ofs_q  <= sp_ofs_d;
			sp_lw_q   <= sp_lw_d;
		end
	end

	// ---------------------------------------------------------------
	// Result queue: up to two pushes per item, one pop per cycle
	// ---------------------------------------------------------------
	uww_pkg::line_item_t          rq_q [uww_pkg::RQ_DEPTH];
	logic [uww_pkg::RQ_PTR_W-1:0] wr_q;
	logic [uww_pkg::RQ_PTR_W-1:0] rd_q;
	logic [uww_pkg::RQ_CNT_W-1:0] cnt_q;
	logic                         push_a;
	logic                         push_b;
	logic                         pop;
	logic [uww_pkg::RQ_CNT_W-1:0] n_push;
	uww_pkg::line_item_t          item_a;

	assign text_stall = cnt_q > uww_pkg::RQ_CNT_W'(uww_pkg::RQ_DEPTH - 2);
	assign line_valid = (cnt_q != '0);
	assign line_item  = rq_q[rd_q];
	assign pop        = line_valid & ~line_stall;

	// first slot takes the break line if any, else the final line
	assign push_a = take & (brk | text_item.last_byte);
	assign push_b = take & brk & text_item.last_byte;
	assign item_a = brk ? brk_line : fin_line;
	assign n_push = uww_pkg::RQ_CNT_W'(push_a) + uww_pkg::RQ_CNT_W'(push_b);

	always_ff @(posedge clk) begin
		if (push_a)
			rq_q[wr_q] <= item_a;
		if (push_b)
			rq_q[wr_q + 1'b1] <= fin_line;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push[uww_pkg::RQ_PTR_W-1:0];
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + n_push - uww_pkg::RQ_CNT_W'(pop);
		end
	end

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= uww_pkg::RQ_CNT_W'(uww_pkg::RQ_DEPTH))
		else $error("result queue over depth");

	a_room_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> cnt_q <= uww_pkg::RQ_CNT_W'(uww_pkg::RQ_DEPTH - 2))
		else $error("item taken without room for two lines");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && text_item.last_byte) |=> (pos_q == '0 && !sp_seen_q && left_q == 2'd0))
		else $error("text state not cleared after last byte");

	a_glyph_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(left_q != 2'd0) |-> (pos_q > {1'b0, start_q}))
		else $error("open glyph outside the open line");

endmodule

@@ test/utf8_greedy_word_wrap_test.sv @@
module utf8_greedy_word_wrap_test;

	// max_width is register 0; no register is wider than 32 bits, so byte address 4*index
	localparam logic [2:0] MAX_WIDTH_ADDR = 3'(4 * uww_pkg::REG_MAX_WIDTH);
	localparam int unsigned WIDTH_CEIL = 32'h3FFFF;
	localparam int unsigned ITEMS_PER_SETTING = 150;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned SETTLE_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic text_valid = 1'b0;
	logic text_stall;
	uww_pkg::text_item_t text_item = '0;

	logic line_valid;
	logic line_stall = 1'b0;
	uww_pkg::line_item_t line_item;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	utf8_greedy_word_wrap dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_item(text_item),
		.line_valid(line_valid),
		.line_stall(line_stall),
		.line_item(line_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 0;
	end

	// Bytes waiting to be offered, and the lines the wrap predictor says must come out
	uww_pkg::text_item_t text_queue[$];
	uww_pkg::line_item_t lines_due[$];
	int unsigned mismatches = 0;

	// Idling odds, in percent; changed between phases
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// Long receiver hold-off, run in its own process once hold_go rises
	bit hold_go = 1'b0;
	logic line_hold = 1'b0;

	// ------------------------------------------------------------------
	// Wrap predictor: its own copy of the register and the text state
	// ------------------------------------------------------------------
	logic [uww_pkg::MAXW_W-1:0] wrap_limit = uww_pkg::MAX_WIDTH_RESET;
	logic [uww_pkg::POS_W-1:0]  text_pos = '0;
	logic [1:0]                 tail_left = '0;
	logic [uww_pkg::OFS_W-1:0]  line_start = '0;
	logic [uww_pkg::LW_W-1:0]   line_width = '0;
	logic                       space_open = 1'b0;
	logic [uww_pkg::OFS_W-1:0]  space_pos = '0;
	logic [uww_pkg::LW_W-1:0]   width_at_space = '0;

	// Bytes taken by the glyph a lead byte opens; anything malformed is one byte
	function automatic int unsigned glyph_bytes(input logic [7:0] lead);
		casez (lead)
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			default:     return 1;
		endcase
	endfunction

	function automatic void close_line(input int unsigned start, input int unsigned len,
			input logic fin);
		uww_pkg::line_item_t line;
		line.line_offset = start[uww_pkg::OFS_W-1:0];
		line.line_bytes = len[uww_pkg::POS_W-1:0];
		line.final_line = fin;
		lines_due.push_back(line);
	endfunction

	function automatic void wrap_byte(input uww_pkg::text_item_t it);
		int unsigned len;
		int unsigned sum;
		if (text_pos < uww_pkg::MAX_TEXT_BYTES) begin
			if (tail_left != 2'd0) begin
				// continuation byte: width ignored, whatever the byte holds
				tail_left = tail_left - 2'd1;
			end else begin
				len = glyph_bytes(it.text_byte);
				// glyph would overflow a non-empty line: close it first
				if (text_pos > line_start &&
						32'(line_width) + 32'(it.glyph_width) > 32'(wrap_limit)) begin
					if (space_open) begin
						// break at the last space, which is dropped
						close_line(line_start, 32'(space_pos) - 32'(line_start), 1'b0);
						line_start = space_pos + 16'd1;
						if (line_width >= width_at_space)
							line_width = line_width - width_at_space;
						else
							line_width = '0;
						space_open = 1'b0;
					end else begin
						close_line(line_start, 32'(text_pos) - 32'(line_start), 1'b0);
						line_start = text_pos[uww_pkg::OFS_W-1:0];
						line_width = '0;
					end
				end
				sum = 32'(line_width) + 32'(it.glyph_width);
				line_width = (sum > WIDTH_CEIL) ? uww_pkg::LW_W'(WIDTH_CEIL)
					: sum[uww_pkg::LW_W-1:0];
				if (len == 1 && it.text_byte == uww_pkg::ASCII_SPACE) begin
					space_open = 1'b1;
					space_pos = text_pos[uww_pkg::OFS_W-1:0];
					width_at_space = line_width;
				end
				tail_left = 2'(len - 1);
			end
			text_pos = text_pos + 1'b1;
		end
		// last byte closes the final line, even past the length limit or mid-glyph
		if (it.last_byte) begin
			close_line(line_start, 32'(text_pos) - 32'(line_start), 1'b1);
			text_pos = '0;
			tail_left = '0;
			line_start = '0;
			line_width = '0;
			space_open = 1'b0;
			space_pos = '0;
			width_at_space = '0;
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: offers the next queued byte; a stalled item is held as it is
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (text_valid && text_stall) begin
			// wait for the block to take it
		end else if (text_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			text_valid <= 1'b1;
			text_item <= text_queue.pop_front();
		end else begin
			text_valid <= 1'b0;
		end
	end

	// Receiver: random stalls, or a solid stall during the hold-off
	always @(posedge clk) begin
		line_stall <= line_hold || ($urandom_range(99) < recv_stall_pct);
	end

	initial begin
		wait (hold_go);
		@(posedge clk) line_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		line_hold <= 1'b0;
	end

	// ------------------------------------------------------------------
	// Monitor: check taken lines against the oldest expectation, then
	// feed any byte taken at this edge to the predictor
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		uww_pkg::line_item_t want;
		if (arst_n) begin
			if (line_valid && !line_stall) begin
				if (lines_due.size() == 0) begin
					$error("unexpected line item: offset %0d, bytes %0d, final %0d",
						line_item.line_offset, line_item.line_bytes, line_item.final_line);
					mismatches++;
				end else begin
					want = lines_due.pop_front();
					check_field("line_offset", 32'(want.line_offset), 32'(line_item.line_offset));
					check_field("line_bytes", 32'(want.line_bytes), 32'(line_item.line_bytes));
					check_field("final_line", 32'(want.final_line), 32'(line_item.final_line));
				end
			end
			if (text_valid && !text_stall)
				wrap_byte(text_item);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Only while idle: write max_width, then read it back
	task automatic set_max_width(input logic [uww_pkg::MAXW_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MAX_WIDTH_ADDR;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		wrap_limit = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[uww_pkg::MAXW_W-1:0] !== value) begin
			$error("max_width readback: expected %0d, got %0d", value,
				prdata[uww_pkg::MAXW_W-1:0]);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic add_byte(input logic [7:0] b, input logic [uww_pkg::GW_W-1:0] w,
			input logic fin);
		uww_pkg::text_item_t it;
		it.text_byte = b;
		it.glyph_width = w;
		it.last_byte = fin;
		text_queue.push_back(it);
	endtask

	// Sender stays quiet until every byte is in and every line is out
	task automatic wait_idle();
		while (text_queue.size() != 0 || text_valid || lines_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [uww_pkg::GW_W-1:0] pick_width();
		if ($urandom_range(99) < 90)
			return uww_pkg::GW_W'($urandom_range(40, 4));
		return uww_pkg::GW_W'($urandom_range(65535));
	endfunction

	// One text of mostly well-formed UTF-8 with words and spaces, some noise;
	// returns the number of bytes queued
	task automatic random_text(output int unsigned count);
		uww_pkg::text_item_t chunk[$];
		uww_pkg::text_item_t it;
		int unsigned len;
		int unsigned r;
		int unsigned n;
		len = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(60, 4);
		while (chunk.size() < len) begin
			r = $urandom_range(99);
			it.last_byte = ($urandom_range(49) == 0);   // stray end mid-text
			it.glyph_width = pick_width();
			if (r < 55) begin
				it.text_byte = 8'($urandom_range(8'h7E, 8'h21));
				chunk.push_back(it);
			end else if (r < 75) begin
				it.text_byte = uww_pkg::ASCII_SPACE;
				chunk.push_back(it);
			end else if (r < 90) begin
				n = $urandom_range(4, 2);
				case (n)
					2: it.text_byte = 8'hC0 | 8'($urandom_range(31));
					3: it.text_byte = 8'hE0 | 8'($urandom_range(15));
					default: it.text_byte = 8'hF0 | 8'($urandom_range(7));
				endcase
				chunk.push_back(it);
				for (int i = 1; i < n; i++) begin
					// tail bytes: usually proper continuations, now and then anything
					it.text_byte = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
						: 8'h80 | 8'($urandom_range(63));
					it.glyph_width = uww_pkg::GW_W'($urandom_range(65535));
					it.last_byte = 1'b0;
					chunk.push_back(it);
				end
			end else begin
				it.text_byte = 8'($urandom_range(255));
				chunk.push_back(it);
			end
		end
		// trimming may cut the closing glyph short
		while (chunk.size() > len)
			void'(chunk.pop_back());
		chunk[chunk.size() - 1].last_byte = 1'b1;
		count = chunk.size();
		foreach (chunk[i])
			text_queue.push_back(chunk[i]);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [uww_pkg::MAXW_W-1:0] limits[8];
		int unsigned queued;
		int unsigned got;

		limits = '{16'd0, 16'd48, 16'd128, 16'hFFFF, 16'd320, 16'd1, 16'd640, 16'd0};
		limits[5] = 16'($urandom_range(65535));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: a 3.0-wide line
		set_max_width(16'd48);
		// space break, then a word too long for the line
		add_byte("a", 16'd16, 1'b0);
		add_byte("b", 16'd16, 1'b0);
		add_byte(" ", 16'd16, 1'b0);
		add_byte("c", 16'd16, 1'b0);
		add_byte("d", 16'd16, 1'b0);
		add_byte("e", 16'd16, 1'b0);
		add_byte("f", 16'd16, 1'b0);
		add_byte("g", 16'd16, 1'b1);
		// two, three and four byte glyphs; tail widths are ignored
		add_byte(8'hC3, 16'd16, 1'b0);
		add_byte(8'hA9, 16'd7, 1'b0);
		add_byte(8'hE2, 16'd16, 1'b0);
		add_byte(8'h82, 16'd0, 1'b0);
		add_byte(8'hAC, 16'hFFFF, 1'b0);
		add_byte(8'hF0, 16'd16, 1'b0);
		add_byte(8'h9F, 16'd1, 1'b0);
		add_byte(8'h98, 16'd2, 1'b0);
		add_byte(8'h80, 16'd3, 1'b1);
		// malformed lead, stray continuation, extreme bytes and widths, glyph cut short
		add_byte(8'hFF, 16'd16, 1'b0);
		add_byte(8'h80, 16'd16, 1'b0);
		add_byte(8'h00, 16'd0, 1'b0);
		add_byte(8'hF8, 16'hFFFF, 1'b0);
		add_byte(8'hE0, 16'd16, 1'b0);
		add_byte(8'h80, 16'd16, 1'b1);
		// one-byte text
		add_byte(uww_pkg::ASCII_SPACE, 16'hFFFF, 1'b1);
		wait_idle();

		// Random texts: four idling phases, two line widths each
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = (p == 1 || p == 3) ? 66 : 0;
			recv_stall_pct = (p == 2 || p == 3) ? 66 : 0;
			if (p == 3) begin
				send_idle_pct = 33;
				recv_stall_pct = 33;
			end
			for (int s = 0; s < 2; s++) begin
				set_max_width(limits[p * 2 + s]);
				// zero width breaks before each glyph of nonzero width but a text's first: hold the
				// receiver off so the result queue fills and the block stalls its input
				if (p == 0 && s == 0)
					hold_go = 1'b1;
				queued = 0;
				while (queued < ITEMS_PER_SETTING) begin
					random_text(got);
					queued += got;
				end
				wait_idle();
			end
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("utf8_greedy_word_wrap: match");
		else
			$display("utf8_greedy_word_wrap: mismatch");
		$finish;
	end

	initial begin
		#(8 * 1000000);
		$display("utf8_greedy_word_wrap: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/uww_pkg.sv
rtl/utf8_greedy_word_wrap.sv
test/utf8_greedy_word_wrap_test.sv
